// ===== rtl/pfc_pkg.sv =====
package pfc_pkg;

  localparam int PitchW           = 16;
  localparam int FreqW            = 30;
  localparam int OctaveW          = 4;
  localparam int SemiW            = 4;
  localparam int StepW            = 9;
  localparam int OffsetW          = 17;
  localparam int RemW             = 13;
  localparam int OctaveCount      = 12;
  localparam int SemiCount        = 12;
  localparam int FineDepth        = 500;
  localparam int StepsPerOctave   = 6000;
  localparam int StepsPerSemi     = 500;
  localparam int OctaveBias       = 6;
  localparam int RomMaxBits       = 32;
  localparam int DefaultFracBits    = 16;
  localparam int DefaultRomWordBits = 24;

  localparam logic [PitchW-1:0] OutOfRangeCode = 16'h8000;
  localparam logic [63:0]       FineStepQ31    = 64'd2147731749;
  localparam logic [63:0]       NanoScale      = 64'd1000000000;
  localparam logic [63:0]       NanoHalf       = 64'd500000000;

  localparam logic [63:0] SemiNanohertz [SemiCount] = '{
    64'd261625565301, 64'd277182630977, 64'd293664767917, 64'd311126983722,
    64'd329627556913, 64'd349228231433, 64'd369994422712, 64'd391995435982,
    64'd415304697580, 64'd440000000000, 64'd466163761518, 64'd493883301256
  };

  typedef logic [RomMaxBits-1:0] semi_rom_t [SemiCount];
  typedef logic [RomMaxBits-1:0] fine_rom_t [FineDepth];

  typedef struct packed {
    logic               valid;
    logic               oor;
    logic [OctaveW-1:0] octave;
  } pipe_tag_t;

  function automatic semi_rom_t build_semi(input int unsigned w);
    semi_rom_t rom;
    for (int i = 0; i < SemiCount; i++) begin
      rom[i] = RomMaxBits'(((SemiNanohertz[i] << (w - 9)) + NanoHalf) / NanoScale);
    end
    return rom;
  endfunction

  function automatic fine_rom_t build_fine(input int unsigned w);
    fine_rom_t   rom;
    logic [63:0] m;
    int unsigned sh;
    m  = 64'd1 << 31;
    sh = RomMaxBits - w;
    for (int i = 0; i < FineDepth; i++) begin
      if (sh == 0) begin
        rom[i] = m[RomMaxBits-1:0];
      end else begin
        rom[i] = RomMaxBits'((m + (64'd1 << (sh - 1))) >> sh);
      end
      m = (m * FineStepQ31 + (64'd1 << 30)) >> 31;
    end
    return rom;
  endfunction

endpackage

// ===== rtl/pfc_split.sv =====
module pfc_split (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              valid_i,
  input  logic signed [pfc_pkg::PitchW-1:0] pitch_code_i,
  output pfc_pkg::pipe_tag_t                tag_o,
  output logic [pfc_pkg::SemiW-1:0]         semitone_o,
  output logic [pfc_pkg::StepW-1:0]         step_o
);

  logic [pfc_pkg::OffsetW-1:0] offset;
  logic [pfc_pkg::OffsetW-1:0] oct_base;
  logic [pfc_pkg::OctaveW-1:0] octave_d;
  logic [pfc_pkg::RemW-1:0]    rem_d, rem_q;
  logic [pfc_pkg::RemW-1:0]    semi_base;
  logic [pfc_pkg::SemiW-1:0]   semitone_d, semitone_q;
  logic [pfc_pkg::StepW-1:0]   step_d, step_q;
  pfc_pkg::pipe_tag_t          tag1_d, tag1_q, tag2_q;

  always_comb begin
    offset   = pfc_pkg::OffsetW'({pitch_code_i[pfc_pkg::PitchW-1], pitch_code_i})
             + pfc_pkg::OffsetW'(pfc_pkg::OctaveBias * pfc_pkg::StepsPerOctave);
    octave_d = '0;
    oct_base = '0;
    for (int j = 1; j < pfc_pkg::OctaveCount; j++) begin
      if (offset >= pfc_pkg::OffsetW'(j * pfc_pkg::StepsPerOctave)) begin
        octave_d = pfc_pkg::OctaveW'(j);
        oct_base = pfc_pkg::OffsetW'(j * pfc_pkg::StepsPerOctave);
      end
    end
    rem_d         = pfc_pkg::RemW'(offset - oct_base);
    tag1_d.valid  = valid_i;
    tag1_d.oor    = (pitch_code_i == pfc_pkg::OutOfRangeCode);
    tag1_d.octave = octave_d;
  end

  always_comb begin
    semitone_d = '0;
    semi_base  = '0;
    for (int j = 1; j < pfc_pkg::SemiCount; j++) begin
      if (rem_q >= pfc_pkg::RemW'(j * pfc_pkg::StepsPerSemi)) begin
        semitone_d = pfc_pkg::SemiW'(j);
        semi_base  = pfc_pkg::RemW'(j * pfc_pkg::StepsPerSemi);
      end
    end
    step_d = pfc_pkg::StepW'(rem_q - semi_base);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag1_q <= '0;
      tag2_q <= '0;
    end else begin
      tag1_q <= tag1_d;
      tag2_q <= tag1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q      <= rem_d;
    semitone_q <= semitone_d;
    step_q     <= step_d;
  end

  assign tag_o      = tag2_q;
  assign semitone_o = semitone_q;
  assign step_o     = step_q;

endmodule

// ===== rtl/pfc_rom.sv =====
module pfc_rom #(
  parameter int RomWordBits = pfc_pkg::DefaultRomWordBits
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  pfc_pkg::pipe_tag_t        tag_i,
  input  logic [pfc_pkg::SemiW-1:0] semitone_i,
  input  logic [pfc_pkg::StepW-1:0] step_i,
  output pfc_pkg::pipe_tag_t        tag_o,
  output logic [RomWordBits-1:0]    semi_o,
  output logic [RomWordBits-1:0]    fine_o
);

  localparam pfc_pkg::semi_rom_t SemiRom = pfc_pkg::build_semi(RomWordBits);
  localparam pfc_pkg::fine_rom_t FineRom = pfc_pkg::build_fine(RomWordBits);

  logic [RomWordBits-1:0] semi_q, fine_q;
  pfc_pkg::pipe_tag_t     tag_q;

  always_ff @(posedge clk_i) begin
    semi_q <= SemiRom[semitone_i][RomWordBits-1:0];
    fine_q <= FineRom[step_i][RomWordBits-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q <= '0;
    end else begin
      tag_q <= tag_i;
    end
  end

  assign tag_o  = tag_q;
  assign semi_o = semi_q;
  assign fine_o = fine_q;

endmodule

// ===== rtl/pfc_scale.sv =====
module pfc_scale #(
  parameter int FracBits    = pfc_pkg::DefaultFracBits,
  parameter int RomWordBits = pfc_pkg::DefaultRomWordBits
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  pfc_pkg::pipe_tag_t        tag_i,
  input  logic [RomWordBits-1:0]    semi_i,
  input  logic [RomWordBits-1:0]    fine_i,
  output logic                      strobe_o,
  output logic [pfc_pkg::FreqW-1:0] frequency_o,
  output logic                      out_of_range_o
);

  localparam int ProdW    = 2 * RomWordBits;
  localparam int ExtW     = ProdW + 8;
  localparam int ShiftTop = 2 * RomWordBits - 10 - FracBits + pfc_pkg::OctaveBias;

  logic [ProdW-1:0]          prod_q;
  pfc_pkg::pipe_tag_t        tag_q;
  logic signed [7:0]         shift_amt;
  logic [6:0]                left_amt;
  logic [ExtW-1:0]           ext, rnd, shifted;
  logic [pfc_pkg::FreqW-1:0] freq_d, freq_q;
  logic                      strobe_q, oor_q;

  always_ff @(posedge clk_i) begin
    prod_q <= semi_i * fine_i;
  end

  always_comb begin
    shift_amt = 8'(ShiftTop) - {4'd0, tag_q.octave};
    left_amt  = 7'(-shift_amt);
    ext       = ExtW'(prod_q);
    rnd       = ext;
    if (shift_amt > 0) begin
      rnd     = ext + (ExtW'(1) << (shift_amt[6:0] - 7'd1));
      shifted = rnd >> shift_amt[6:0];
    end else begin
      shifted = ext << left_amt;
    end
    if (tag_q.oor) begin
      freq_d = '0;
    end else if (|shifted[ExtW-1:pfc_pkg::FreqW]) begin
      freq_d = '1;
    end else begin
      freq_d = shifted[pfc_pkg::FreqW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q    <= '0;
      strobe_q <= 1'b0;
    end else begin
      tag_q    <= tag_i;
      strobe_q <= tag_q.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    freq_q <= freq_d;
    oor_q  <= tag_q.oor;
  end

  assign strobe_o       = strobe_q;
  assign frequency_o    = freq_q;
  assign out_of_range_o = oor_q;

endmodule

// ===== rtl/pitch_to_frequency_converter.sv =====
// Converts a pitch code (fifth-cents from middle C, 6000 per octave, A4 = 440 Hz) into a
// frequency with FracBits fractional bits, rounded to nearest. One transaction is taken in
// every cycle and busy never rises. Each result is shown on strobe_o for one cycle, once its
// start has passed the six-stage pipeline (input register, two constant-divide stages,
// ROM read, multiply, round and shift). The receiver cannot stall: a result that is not
// taken in its strobe cycle is gone. A code of -32768 sets out_of_range_o and gives a
// frequency of zero.
module pitch_to_frequency_converter #(
  parameter int FracBits    = pfc_pkg::DefaultFracBits,
  parameter int RomWordBits = pfc_pkg::DefaultRomWordBits
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic signed [pfc_pkg::PitchW-1:0] pitch_code_i,
  output logic                              strobe_o,
  output logic [pfc_pkg::FreqW-1:0]         frequency_o,
  output logic                              out_of_range_o
);

  localparam int Latency = 6;

  logic                              in_valid_q;
  logic signed [pfc_pkg::PitchW-1:0] pitch_q;
  logic                              accept;
  pfc_pkg::pipe_tag_t                split_tag, rom_tag;
  logic [pfc_pkg::SemiW-1:0]         semitone;
  logic [pfc_pkg::StepW-1:0]         step;
  logic [RomWordBits-1:0]            semi_word, fine_word;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    pitch_q <= pitch_code_i;
  end

  pfc_split u_split (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (in_valid_q),
    .pitch_code_i (pitch_q),
    .tag_o        (split_tag),
    .semitone_o   (semitone),
    .step_o       (step)
  );

  pfc_rom #(
    .RomWordBits (RomWordBits)
  ) u_rom (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .tag_i      (split_tag),
    .semitone_i (semitone),
    .step_i     (step),
    .tag_o      (rom_tag),
    .semi_o     (semi_word),
    .fine_o     (fine_word)
  );

  pfc_scale #(
    .FracBits    (FracBits),
    .RomWordBits (RomWordBits)
  ) u_scale (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .tag_i          (rom_tag),
    .semi_i         (semi_word),
    .fine_i         (fine_word),
    .strobe_o       (strobe_o),
    .frequency_o    (frequency_o),
    .out_of_range_o (out_of_range_o)
  );

  a_result_follows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##Latency strobe_o)
    else $error("transaction lost in pipeline");

  a_no_spurious : assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && $past(rst_ni, Latency) |-> $past(accept, Latency))
    else $error("result without transaction");

  a_oor_flag : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (pitch_code_i == pfc_pkg::OutOfRangeCode) |-> ##Latency out_of_range_o)
    else $error("out-of-range code not flagged");

  a_oor_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && out_of_range_o |-> (frequency_o == '0))
    else $error("out-of-range result not zero");

endmodule
